// File: sv/rse_pkg.sv
// shared constants, types and field arithmetic for the reed-solomon encoder
package rse_pkg;

  // default and hard limit on the parity count
  localparam int MAX_PARITY_DEF = 32;
  localparam int MAX_OUT        = 32;

  // reset values of the configuration registers
  localparam logic [7:0] MSG_LEN_RST = 8'd223;
  localparam logic [5:0] PARITY_RST  = 6'd32;

  // low byte of the field polynomial x^8 + x^4 + x^3 + x^2 + 1
  localparam logic [7:0] GF_POLY_LOW = 8'h1d;

  // configuration register indexes
  localparam logic REG_MSG_LEN = 1'b0;
  localparam logic REG_PARITY  = 1'b1;

  // control from the top level towards the remainder datapath
  typedef struct packed {
    logic restart;
    logic gen_busy;
  } rse_ctrl_t;

  // multiply by the primitive element
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
  endfunction

  // full field multiply, shift and add over the eight bits of b
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage

// File: sv/rse_gen_builder.sv
// generator polynomial builder, one root multiplied in per cycle
module rse_gen_builder #(
  parameter int MAX_PARITY = 32,
  parameter int CW         = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CW-1:0]    p_eff,
  output logic             busy,
  output logic [7:0]       coeff [MAX_PARITY]
);
  import rse_pkg::*;

  logic [7:0]    g [MAX_PARITY+1];
  logic [7:0]    root;
  logic [CW-1:0] deg;
  logic [CW-1:0] deg_next;

  assign deg_next = deg + CW'(1);

  // multiply g by (x + root) each cycle, all coefficients in parallel
  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      deg  <= '0;
      root <= 8'd1;
      g[0] <= 8'd1;
      for (int k = 1; k <= MAX_PARITY; k++) g[k] <= 8'd0;
    end else if (busy) begin
      for (int k = 1; k <= MAX_PARITY; k++) g[k] <= g[k] ^ gf_mul(g[k-1], root);
      root <= gf_xtime(root);
      deg  <= deg_next;
      if (deg_next == p_eff) busy <= 1'b0;
    end
  end

  // non-leading coefficients, highest degree first
  always_comb begin
    for (int k = 0; k < MAX_PARITY; k++) coeff[k] = g[k+1];
  end

endmodule

// File: sv/rse_lfsr.sv
// input register, byte counter and remainder shift register
module rse_lfsr #(
  parameter int MAX_PARITY = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  rse_pkg::rse_ctrl_t ctrl,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic [7:0]        len_eff,
  input  logic [7:0]        coeff [MAX_PARITY],
  input  logic              out_free,
  output logic              emit,
  output logic [7:0]        parity [MAX_PARITY]
);
  import rse_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic [7:0] count;
  logic [7:0] count_next;
  logic [7:0] rem [MAX_PARITY];
  logic [7:0] fb;
  logic       last;
  logic       advance;
  logic       accept;

  // feedback through the generator into the shifted remainder
  assign fb = in_byte ^ rem[0];
  always_comb begin
    for (int k = 0; k < MAX_PARITY - 1; k++) parity[k] = rem[k+1] ^ gf_mul(fb, coeff[k]);
    parity[MAX_PARITY-1] = gf_mul(fb, coeff[MAX_PARITY-1]);
  end

  // codeword end and stall decision
  assign count_next = count + 8'd1;
  assign last       = count_next >= len_eff;
  assign advance    = in_valid && (!last || out_free);
  assign emit       = advance && last;
  assign s_tready   = !ctrl.gen_busy && (!in_valid || advance);
  assign accept     = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_byte <= s_tdata;
  end

  // remainder and count, cleared at the end of each codeword
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      count <= 8'd0;
      for (int k = 0; k < MAX_PARITY; k++) rem[k] <= 8'd0;
    end else if (advance) begin
      if (last) begin
        count <= 8'd0;
        for (int k = 0; k < MAX_PARITY; k++) rem[k] <= 8'd0;
      end else begin
        count <= count_next;
        for (int k = 0; k < MAX_PARITY; k++) rem[k] <= parity[k];
      end
    end
  end

endmodule

// File: sv/rse_parity_out.sv
// parity output buffer, drained one item per cycle while m_tready is high
module rse_parity_out #(
  parameter int MAX_PARITY = 32,
  parameter int CW         = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [7:0]    parity [MAX_PARITY],
  input  logic [CW-1:0] p_eff,
  output logic          free,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast
);
  logic [7:0]    pb [MAX_PARITY];
  logic [CW-1:0] left;
  logic          pop;

  assign m_tvalid = left != '0;
  assign m_tlast  = left == CW'(1);
  assign m_tdata  = pb[0];
  assign pop      = m_tvalid && m_tready;
  assign free     = (left == '0) || (m_tlast && m_tready);

  // items still to deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= p_eff;
    end else if (pop) begin
      left <= left - CW'(1);
    end
  end

  // snapshot of the remainder, shifted towards the port
  always_ff @(posedge clk) begin
    if (load) begin
      pb <= parity;
    end else if (pop) begin
      for (int k = 0; k < MAX_PARITY - 1; k++) pb[k] <= pb[k+1];
      pb[MAX_PARITY-1] <= 8'd0;
    end
  end

endmodule

// File: sv/rs_systematic_encoder.sv
// systematic reed-solomon encoder over gf(256), top level
//
// Message bytes enter on the s_ group, one item per byte in codeword order.
// After message_length bytes the encoder delivers parity_count parity bytes on
// the m_ group, highest degree first, with m_tlast on the final one.
// Throughput is one byte per cycle on both sides when neither side stalls:
// the remainder update for a byte is one pass of parallel field multipliers
// between the input register and the remainder register.
// The last message byte passes the input register, then its remainder is
// loaded into the parity buffer. Parity bytes drain from the buffer while the
// next codeword's bytes are taken; besides the generator rebuild, the input
// stalls only when a codeword ends before the previous parity burst is taken.
// A stalled receiver holds m_tdata and m_tlast steady.
// Reset and any configuration write clear the remainder and byte count and
// rebuild the generator polynomial, one degree per cycle, so s_tready stays
// low until the rebuild is done.
// Registers on the apb port: 0x0 message_length, 0x4 parity_count.
module rs_systematic_encoder #(
  parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] parity_byte
  output logic        m_tlast,   // last_parity
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rse_pkg::*;

  localparam int LIM = (MAX_PARITY < MAX_OUT) ? MAX_PARITY : MAX_OUT;
  localparam int CW  = $clog2(LIM + 1);

  logic [7:0]    msg_len;
  logic [5:0]    par_cnt;
  logic [7:0]    len_eff;
  logic [CW-1:0] p_eff;
  logic          cfg_wr;
  logic          gen_busy;
  logic          emit;
  logic          out_free;
  rse_ctrl_t     ctrl;
  logic [7:0]    coeff  [MAX_PARITY];
  logic [7:0]    parity [MAX_PARITY];

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len <= MSG_LEN_RST;
      par_cnt <= PARITY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MSG_LEN: msg_len <= pwdata[7:0];
        REG_PARITY:  par_cnt <= pwdata[5:0];
        default:     msg_len <= msg_len;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_PARITY) ? {26'd0, par_cnt} : {24'd0, msg_len};

  // effective lengths, zero taken as one and parity saturated
  assign len_eff = (msg_len == 8'd0) ? 8'd1 : msg_len;
  always_comb begin
    if (par_cnt == 6'd0) begin
      p_eff = CW'(1);
    end else if (int'(par_cnt) > LIM) begin
      p_eff = CW'(LIM);
    end else begin
      p_eff = CW'(par_cnt);
    end
  end

  assign ctrl.restart  = cfg_wr;
  assign ctrl.gen_busy = gen_busy;

  rse_gen_builder #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_gen (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wr),
    .p_eff (p_eff),
    .busy  (gen_busy),
    .coeff (coeff)
  );

  rse_lfsr #(
    .MAX_PARITY (MAX_PARITY)
  ) u_lfsr (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .len_eff  (len_eff),
    .coeff    (coeff),
    .out_free (out_free),
    .emit     (emit),
    .parity   (parity)
  );

  rse_parity_out #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (emit),
    .parity   (parity),
    .p_eff    (p_eff),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sv/rse_checker.sv
// port-level checks for the encoder, bound to the top level
module rse_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       psel,
  input logic       penable,
  input logic       pwrite
);

  // a stalled parity item holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("parity item changed while stalled");

  // generator rebuild after reset blocks the input
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during generator build after reset");

  // a register write restarts the generator build
  assert property (@(posedge clk) psel && penable && pwrite |=> !s_tready)
    else $error("input ready right after a register write");

  // no parity is pending straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("parity item valid after reset");

endmodule

bind rs_systematic_encoder rse_checker u_rse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite)
);
